FILE: rtl/utf8cpd_pkg.sv
package utf8cpd_pkg;

   // Field widths of the stream words.
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned CP_W        = 27;
   localparam int unsigned CNT_OUT_W   = 16;
   localparam int unsigned CSR_W       = 16;
   localparam int unsigned LEFT_W      = 3;

   // Result word layout: code_point in the low bits, char_count above it,
   // zero padded to a whole number of bytes.
   localparam int unsigned RSP_CP_LSB  = 0;
   localparam int unsigned RSP_CNT_LSB = CP_W;
   localparam int unsigned RSP_USED_W  = CP_W + CNT_OUT_W;
   localparam int unsigned RSP_TDATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int unsigned RSP_PAD_W   = RSP_TDATA_W - RSP_USED_W;

   // Lead byte classification masks and patterns.
   localparam logic [BYTE_W-1:0] ASCII_MASK  = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_PAT   = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_PAT   = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_PAT   = 8'hF0;

   // Continuation counts left after each kind of lead byte.
   localparam logic [LEFT_W-1:0] LEFT_LEAD2  = 3'd1;
   localparam logic [LEFT_W-1:0] LEFT_LEAD3  = 3'd2;
   localparam logic [LEFT_W-1:0] LEFT_LEAD4  = 3'd3;
   localparam logic [LEFT_W-1:0] LEFT_LEAD5  = 3'd4;

   // Payload masks.
   localparam logic [BYTE_W-1:0] CONT_MASK   = 8'h3F;
   localparam logic [BYTE_W-1:0] LEAD2_PAY   = 8'h1F;
   localparam logic [BYTE_W-1:0] LEAD3_PAY   = 8'h0F;
   localparam logic [BYTE_W-1:0] LEAD4_PAY   = 8'h07;
   localparam logic [BYTE_W-1:0] LEAD5_PAY   = 8'h03;

endpackage

FILE: rtl/utf8_code_point_decoder_core.sv
// A result word appears on rsp_ in the cycle after the byte that completes it is taken.
// Throughput: one byte per cycle; the single output register sets this, and a byte is
// taken whenever that register is empty or is being drained in the same cycle.
// Reset (synchronous, active high) clears the decode state, the character limit and the
// output valid flag; the block takes bytes in the first cycle after reset.
module utf8_code_point_decoder_core #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Configuration: most code points per string, zero means no limit.
   input  logic                                  csr_wr_en,
   input  logic [utf8cpd_pkg::CSR_W-1:0]         csr_wr_data,
   // Input bytes.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [utf8cpd_pkg::BYTE_W-1:0]        req_tdata,   // [7:0] in_byte
   input  logic                                  req_tlast,   // end_of_string
   // Result words.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [utf8cpd_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // [26:0] code_point,
                                                              // [42:27] char_count, zeros above
   output logic                                  rsp_tuser,   // has_char
   output logic                                  rsp_tlast    // is_last
);

   // The limit compare runs at the wider of the counter and the register.
   localparam int unsigned CMP_W = (COUNT_BITS > utf8cpd_pkg::CSR_W) ?
                                   COUNT_BITS : utf8cpd_pkg::CSR_W;
   localparam int unsigned OUT_W = (COUNT_BITS > utf8cpd_pkg::CNT_OUT_W) ?
                                   COUNT_BITS : utf8cpd_pkg::CNT_OUT_W;

   // Decode state for the string in progress.
   logic [utf8cpd_pkg::LEFT_W-1:0]    left_ff, left_in;
   logic [utf8cpd_pkg::CP_W-1:0]      acc_ff, acc_in;
   logic [COUNT_BITS-1:0]             count_ff, count_in;
   logic                              halted_ff, halted_in;
   logic [utf8cpd_pkg::CSR_W-1:0]     max_chars_ff;

   // Output register.
   logic                              rsp_valid_ff;
   logic [utf8cpd_pkg::CP_W-1:0]      rsp_cp_ff, rsp_cp_in;
   logic [utf8cpd_pkg::CNT_OUT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic                              rsp_has_ff, rsp_last_ff;

   logic                              take;
   logic                              have;
   logic                              emit;
   logic                              limit_hit;
   logic [CMP_W-1:0]                  count_cmp;
   logic [CMP_W-1:0]                  max_cmp;
   logic [OUT_W-1:0]                  count_out;
   logic [utf8cpd_pkg::BYTE_W-1:0]    b;

   // A byte is taken when the output register is free now or frees this cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;
   assign b          = req_tdata;

   assign count_cmp = CMP_W'(count_ff);
   assign max_cmp   = CMP_W'(max_chars_ff);
   assign limit_hit = (max_chars_ff != '0) && (count_cmp >= max_cmp);

   // Byte decode. A lead byte is due when no continuation bytes are pending; the
   // limit is checked only there, so the limit never cuts off a sequence in flight.
   always_comb begin
      left_in   = left_ff;
      acc_in    = acc_ff;
      halted_in = halted_ff;
      have      = 1'b0;
      rsp_cp_in = '0;
      if (!halted_ff) begin
         if (left_ff == '0) begin
            if (limit_hit) begin
               halted_in = 1'b1;
            end else if ((b & utf8cpd_pkg::ASCII_MASK) == '0) begin
               have      = 1'b1;
               rsp_cp_in = utf8cpd_pkg::CP_W'(b);
            end else if ((b & utf8cpd_pkg::LEAD2_MASK) == utf8cpd_pkg::LEAD2_PAT) begin
               left_in = utf8cpd_pkg::LEFT_LEAD2;
               acc_in  = utf8cpd_pkg::CP_W'(b & utf8cpd_pkg::LEAD2_PAY);
            end else if ((b & utf8cpd_pkg::LEAD3_MASK) == utf8cpd_pkg::LEAD3_PAT) begin
               left_in = utf8cpd_pkg::LEFT_LEAD3;
               acc_in  = utf8cpd_pkg::CP_W'(b & utf8cpd_pkg::LEAD3_PAY);
            end else if ((b & utf8cpd_pkg::LEAD4_MASK) == utf8cpd_pkg::LEAD4_PAT) begin
               left_in = utf8cpd_pkg::LEFT_LEAD4;
               acc_in  = utf8cpd_pkg::CP_W'(b & utf8cpd_pkg::LEAD4_PAY);
            end else begin
               // Stray continuation bytes and 11111xxx start a five-byte sequence.
               left_in = utf8cpd_pkg::LEFT_LEAD5;
               acc_in  = utf8cpd_pkg::CP_W'(b & utf8cpd_pkg::LEAD5_PAY);
            end
         end else begin
            // Continuation bytes contribute their low six bits; the top bits
            // are not checked. The oldest bits fall off the top.
            acc_in  = {acc_ff[utf8cpd_pkg::CP_W-7:0], b[5:0]};
            left_in = left_ff - 1'b1;
            if (left_ff == utf8cpd_pkg::LEFT_W'(1)) begin
               have      = 1'b1;
               rsp_cp_in = acc_in;
            end
         end
      end
   end

   // The emitted count saturates at its full range.
   always_comb begin
      count_in = count_ff;
      if (have && (count_ff != '1)) begin
         count_in = count_ff + 1'b1;
      end
   end

   // The reported count saturates at the width of the result field.
   assign count_out  = OUT_W'(count_in);
   assign rsp_cnt_in = (count_out > OUT_W'({utf8cpd_pkg::CNT_OUT_W{1'b1}})) ?
                       '1 : count_out[utf8cpd_pkg::CNT_OUT_W-1:0];

   // Every completed code point gives a word, and so does the last byte of a string.
   assign emit = have || req_tlast;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         acc_ff       <= '0;
         count_ff     <= '0;
         halted_ff    <= 1'b0;
         max_chars_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_chars_ff <= csr_wr_data;
         end
         if (take) begin
            if (req_tlast) begin
               // The end of a string drops any partial sequence and clears the count and the halt.
               left_ff   <= '0;
               acc_ff    <= '0;
               count_ff  <= '0;
               halted_ff <= 1'b0;
            end else begin
               left_ff   <= left_in;
               acc_ff    <= acc_in;
               count_ff  <= count_in;
               halted_ff <= halted_in;
            end
            rsp_valid_ff <= emit;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload; loaded only with a word that is going out.
   always_ff @(posedge clock) begin
      if (take && emit) begin
         rsp_cp_ff   <= rsp_cp_in;
         rsp_cnt_ff  <= rsp_cnt_in;
         rsp_has_ff  <= have;
         rsp_last_ff <= req_tlast;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{utf8cpd_pkg::RSP_PAD_W{1'b0}}, rsp_cnt_ff, rsp_cp_ff};
   assign rsp_tuser  = rsp_has_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: rtl/utf8cpd_checker.sv
module utf8cpd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [utf8cpd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                                rsp_tuser,
   input logic                                rsp_tlast
);

   // A stalled result word keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A word without a character only closes a string.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast
         && (rsp_tdata[utf8cpd_pkg::CP_W-1:0] == '0))
      else $error("empty word that is not the end of a string");

   // A word with a character counts at least that character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata[utf8cpd_pkg::RSP_CNT_LSB +: utf8cpd_pkg::CNT_OUT_W] != '0)
      else $error("character word with zero count");

endmodule

bind utf8_code_point_decoder_core utf8cpd_checker u_utf8cpd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
